[rtl/rdae_pkg.sv]
// ----------------------------------------------------------------------------
// rdae_pkg: shared types and constants for the radial dead zone block
// Sample format, register layout, beat structs, sequencer states and the
// load/step control word of the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package rdae_pkg;

   // sample format: signed, SAMPLE_BITS-1 fraction bits
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;

   // one result bit per cycle in every serial unit
   localparam int STEPS = SAMPLE_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   // register fields have 15 fraction bits: dead zone Q0.15, threshold Q1.15
   localparam int CFG_FRAC = 15;
   localparam int DZ_W     = 15;
   localparam int THR_W    = 16;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [DZ_W-1:0]  DZ_RESET  = 15'd4915;
   localparam logic [THR_W-1:0] THR_RESET = 16'd33;

   // register select (address bit 2)
   localparam logic REG_DEAD_ZONE = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_REARM  = 1'b1;

   // axis codes
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   localparam logic [SAMPLE_BITS-1:0] ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {FRAC_BITS{1'b1}}};

   typedef struct packed {
      logic                          req_type;
      logic signed [SAMPLE_BITS-1:0] stick_x;
      logic signed [SAMPLE_BITS-1:0] stick_y;
   } req_beat_type;

   typedef struct packed {
      logic                          axis_id;
      logic signed [SAMPLE_BITS-1:0] axis_value;
      logic                          last_of_run;
   } rsp_beat_type;

   typedef struct packed {
      logic load;
      logic step;
   } step_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_SCALE,
      ST_AXIS_MUL,
      ST_AXIS_DIV,
      ST_DECIDE,
      ST_EMIT
   } state_type;

endpackage

[rtl/rdae_smul.sv]
// ----------------------------------------------------------------------------
// rdae_smul: bit-serial unsigned multiplier
// Shift-add, multiplier bits consumed LSB first from the low half of the
// product register; one bit per step, narrow adder on the high half.
// ----------------------------------------------------------------------------
module rdae_smul (
   input  logic                                  clock,
   input  rdae_pkg::step_ctl_type                ctl,
   input  logic [rdae_pkg::SAMPLE_BITS-1:0]      mcand,
   input  logic [rdae_pkg::SAMPLE_BITS-1:0]      mplier,
   output logic [2*rdae_pkg::SAMPLE_BITS-1:0]    product
);
   import rdae_pkg::*;

   localparam int W = SAMPLE_BITS;

   logic [2*W-1:0] prod_ff, prod_in;
   logic [W:0]     sum;

   always_comb begin
      sum     = {1'b0, prod_ff[2*W-1:W]} + (prod_ff[0] ? {1'b0, mcand} : {(W+1){1'b0}});
      prod_in = prod_ff;
      if (ctl.load) begin
         prod_in = {{W{1'b0}}, mplier};
      end else if (ctl.step) begin
         prod_in = {sum, prod_ff[W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

[rtl/rdae_isqrt.sv]
// ----------------------------------------------------------------------------
// rdae_isqrt: digit-by-digit integer square root
// Two radicand bits enter per step, one root bit leaves; the final
// remainder is kept so the caller can tell an exact square.
// ----------------------------------------------------------------------------
module rdae_isqrt (
   input  logic                                  clock,
   input  rdae_pkg::step_ctl_type                ctl,
   input  logic [2*rdae_pkg::SAMPLE_BITS-1:0]    radicand,
   output logic [rdae_pkg::SAMPLE_BITS-1:0]      root,
   output logic                                  rem_nz
);
   import rdae_pkg::*;

   localparam int W = SAMPLE_BITS;

   logic [2*W-1:0] rad_ff, rad_in;
   logic [W:0]     rem_ff, rem_in;
   logic [W-1:0]   root_ff, root_in;
   logic [W+2:0]   trial_acc, trial_sub, diff;
   logic           fits;

   always_comb begin
      trial_acc = {rem_ff, rad_ff[2*W-1:2*W-2]};
      trial_sub = {1'b0, root_ff, 2'b01};
      diff      = trial_acc - trial_sub;
      fits      = trial_acc >= trial_sub;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (ctl.load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.step) begin
         rad_in  = {rad_ff[2*W-3:0], 2'b00};
         rem_in  = fits ? diff[W:0] : trial_acc[W:0];
         root_in = {root_ff[W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root   = root_ff;
   assign rem_nz = |rem_ff;

endmodule

[rtl/rdae_sdiv.sv]
// ----------------------------------------------------------------------------
// rdae_sdiv: restoring bit-serial divider
// Partial remainder starts below the divisor, dividend low bits shift in
// MSB first and quotient bits shift out into the same register.
// ----------------------------------------------------------------------------
module rdae_sdiv (
   input  logic                                  clock,
   input  rdae_pkg::step_ctl_type                ctl,
   input  logic [rdae_pkg::SAMPLE_BITS-1:0]      rem_init,
   input  logic [rdae_pkg::SAMPLE_BITS-1:0]      low_bits,
   input  logic [rdae_pkg::SAMPLE_BITS-1:0]      divisor,
   output logic [rdae_pkg::SAMPLE_BITS-1:0]      quotient
);
   import rdae_pkg::*;

   localparam int W = SAMPLE_BITS;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W:0]   trial, diff;
   logic         fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[W-1]};
      diff   = trial - {1'b0, divisor};
      fits   = trial >= {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctl.load) begin
         rem_in = rem_init;
         quo_in = low_bits;
      end else if (ctl.step) begin
         rem_in = fits ? diff[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

[rtl/radial_deadzone_axis_events.sv]
// ----------------------------------------------------------------------------
// radial_deadzone_axis_events: scaled radial dead zone with axis change beats
// Two-axis stick samples are shaped radially and reported per axis when
// they move by more than the change threshold.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per request: a stick sample or a rearm. The block
//   takes one request at a time; req_stall is high while a sample is worked.
//   A rearm clears the last sent values and is absorbed in its accept cycle.
//   A live sample runs the serial chain in order: squares, square root, scale
//   divide, axis multiply and axis divide, on one-bit-per-cycle units, then
//   decide and emit; a sample inside the dead zone goes from the square
//   root straight to decide.
//   Each sample gives zero, one or two rsp_* beats (X before Y); last_of_run
//   marks the final one. A single output register holds the pending beat;
//   while rsp_stall is high it holds, and the next request is taken as soon
//   as the last beat of a sample is in that register.
//   psel/penable/pwrite write dead_zone (address 0) and change_threshold
//   (address 4); write only while idle. pready is always high.
//   Reset (synchronous) restores the register defaults, clears the sent
//   values, and leaves the first sample to report both axes.
// ----------------------------------------------------------------------------
module radial_deadzone_axis_events (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rdae_pkg::req_beat_type            req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rdae_pkg::rsp_beat_type            rsp_data,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rdae_pkg::ADDR_W-1:0]       paddr,
   input  logic [rdae_pkg::DATA_W-1:0]       pwdata,
   output logic [rdae_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import rdae_pkg::*;

   localparam int W = SAMPLE_BITS;

   // Rescale a Q0.15 register to the sample format (shift up or down).
   function automatic logic [FRAC_BITS-1:0] dz_to_sample(input logic [DZ_W-1:0] v);
      logic [DZ_W+FRAC_BITS-1:0] w;
      w = {{FRAC_BITS{1'b0}}, v} << FRAC_BITS;
      w = w >> CFG_FRAC;
      return w[FRAC_BITS-1:0];
   endfunction

   function automatic logic [W-1:0] thr_to_sample(input logic [THR_W-1:0] v);
      logic [THR_W+FRAC_BITS-1:0] w;
      w = {{FRAC_BITS{1'b0}}, v} << FRAC_BITS;
      w = w >> CFG_FRAC;
      return w[W-1:0];
   endfunction

   function automatic logic [W-1:0] abs_mag(input logic [W-1:0] v);
      return v[W-1] ? (~v + W'(1)) : v;
   endfunction

   // Apply the sign; the positive side saturates at the largest code.
   function automatic logic [W-1:0] shape_axis(input logic neg, input logic [W-1:0] r);
      logic [W-1:0] res;
      if (neg) begin
         res = ~r + W'(1);
      end else if (r > MAX_POS) begin
         res = MAX_POS;
      end else begin
         res = r;
      end
      return res;
   endfunction

   // Full signed difference magnitude.
   function automatic logic [W:0] abs_diff(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] d;
      d = {a[W-1], a} - {b[W-1], b};
      return d[W] ? (~d + (W+1)'(1)) : d;
   endfunction

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DZ_W-1:0]      dz_ff;
   logic [THR_W-1:0]     thr_ff;
   logic [W-1:0]         sent_x_ff, sent_y_ff;
   logic                 primed_ff;
   logic                 live_ff;
   logic                 ev_x_ff, ev_y_ff;
   logic [W-1:0]         x_ff, y_ff;
   logic                 rsp_valid_ff;
   rsp_beat_type         rsp_data_ff;

   // ---------------------------------------------------------------- datapath
   logic                 req_fire, rsp_free, wr_fire, phase_end;
   logic [W-1:0]         mag_x, mag_y;
   logic [W-1:0]         dz_w, thr_s;
   logic [W-1:0]         root;
   logic                 rem_nz, live_c;
   logic [W-1:0]         clamp, num, den;
   logic [2*W-1:0]       scaled_num;
   logic [2*W-1:0]       prod_x, prod_y;
   logic [W-1:0]         quo_x, quo_y;
   logic [W-1:0]         mplier_x, mplier_y;
   logic [W-1:0]         rem_init_x, rem_init_y, low_x, low_y, divisor;
   logic [W-1:0]         shaped_x, shaped_y;
   logic                 hit_x, hit_y;
   step_ctl_type         mul_ctl, root_ctl, div_ctl;
   logic                 capture_live, out_load;

   assign req_fire = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign wr_fire  = psel && penable && pwrite;
   assign phase_end = cnt_ff == CNT_W'(STEPS);

   assign mag_x = abs_mag(x_ff);
   assign mag_y = abs_mag(y_ff);
   assign dz_w  = {1'b0, dz_to_sample(dz_ff)};
   assign thr_s = thr_to_sample(thr_ff);

   // Live when m^2 > dz^2: from the floor root and whether it was exact.
   assign live_c = (root > dz_w) || ((root == dz_w) && rem_nz);

   assign clamp      = (root > ONE_Q) ? ONE_Q : root;
   assign num        = (clamp > dz_w) ? (clamp - dz_w) : '0;
   assign den        = ONE_Q - dz_w;
   assign scaled_num = {1'b0, num, {FRAC_BITS{1'b0}}};

   // Squares first, then |v| * scale; scale is the X lane's quotient.
   always_comb begin
      if (state_ff == ST_SQUARE) begin
         mplier_x = mag_x;
         mplier_y = mag_y;
      end else begin
         mplier_x = quo_x;
         mplier_y = quo_x;
      end
   end

   // Scale divide (both lanes run it, X is used), then per-axis divide by root.
   always_comb begin
      if (state_ff == ST_SCALE) begin
         rem_init_x = scaled_num[2*W-1:W];
         low_x      = scaled_num[W-1:0];
         rem_init_y = scaled_num[2*W-1:W];
         low_y      = scaled_num[W-1:0];
         divisor    = den;
      end else begin
         rem_init_x = prod_x[2*W-1:W];
         low_x      = prod_x[W-1:0];
         rem_init_y = prod_y[2*W-1:W];
         low_y      = prod_y[W-1:0];
         divisor    = root;
      end
   end

   rdae_smul u_mul_x (
      .clock   (clock),
      .ctl     (mul_ctl),
      .mcand   (mag_x),
      .mplier  (mplier_x),
      .product (prod_x)
   );

   rdae_smul u_mul_y (
      .clock   (clock),
      .ctl     (mul_ctl),
      .mcand   (mag_y),
      .mplier  (mplier_y),
      .product (prod_y)
   );

   rdae_isqrt u_isqrt (
      .clock    (clock),
      .ctl      (root_ctl),
      .radicand (prod_x + prod_y),
      .root     (root),
      .rem_nz   (rem_nz)
   );

   rdae_sdiv u_div_x (
      .clock    (clock),
      .ctl      (div_ctl),
      .rem_init (rem_init_x),
      .low_bits (low_x),
      .divisor  (divisor),
      .quotient (quo_x)
   );

   rdae_sdiv u_div_y (
      .clock    (clock),
      .ctl      (div_ctl),
      .rem_init (rem_init_y),
      .low_bits (low_y),
      .divisor  (divisor),
      .quotient (quo_y)
   );

   // Shaped values and change tests; zero inside the dead zone.
   assign shaped_x = live_ff ? shape_axis(x_ff[W-1], quo_x) : '0;
   assign shaped_y = live_ff ? shape_axis(y_ff[W-1], quo_y) : '0;
   assign hit_x    = !primed_ff || (abs_diff(shaped_x, sent_x_ff) > {1'b0, thr_s});
   assign hit_y    = !primed_ff || (abs_diff(shaped_y, sent_y_ff) > {1'b0, thr_s});

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.req_type == REQ_SAMPLE)) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (phase_end) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (phase_end) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if ((cnt_ff == '0) && !live_c) begin
               state_in = ST_DECIDE;
            end else if (phase_end) begin
               state_in = ST_AXIS_MUL;
            end
         end
         ST_AXIS_MUL: begin
            if (phase_end) state_in = ST_AXIS_DIV;
         end
         ST_AXIS_DIV: begin
            if (phase_end) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // leave once the last pending beat goes into the output register, or at once if none
            if ((!ev_x_ff && !ev_y_ff) || (rsp_free && !(ev_x_ff && ev_y_ff))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      mul_ctl      = '0;
      root_ctl     = '0;
      div_ctl      = '0;
      capture_live = 1'b0;
      out_load     = 1'b0;
      cnt_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SQUARE, ST_AXIS_MUL: begin
            mul_ctl.load = cnt_ff == '0;
            mul_ctl.step = cnt_ff != '0;
            if (!phase_end) cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_ROOT: begin
            root_ctl.load = cnt_ff == '0;
            root_ctl.step = cnt_ff != '0;
            if (!phase_end) cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_SCALE: begin
            capture_live = cnt_ff == '0;
            div_ctl.load = (cnt_ff == '0) && live_c;
            div_ctl.step = cnt_ff != '0;
            if (!phase_end && !((cnt_ff == '0) && !live_c)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_AXIS_DIV: begin
            div_ctl.load = cnt_ff == '0;
            div_ctl.step = cnt_ff != '0;
            if (!phase_end) cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_DECIDE: begin
         end
         ST_EMIT: begin
            out_load = rsp_free && (ev_x_ff || ev_y_ff);
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         dz_ff        <= DZ_RESET;
         thr_ff       <= THR_RESET;
         sent_x_ff    <= '0;
         sent_y_ff    <= '0;
         primed_ff    <= 1'b0;
         live_ff      <= 1'b0;
         ev_x_ff      <= 1'b0;
         ev_y_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;

         if (wr_fire) begin
            if (paddr[2] == REG_DEAD_ZONE) begin
               dz_ff <= pwdata[DZ_W-1:0];
            end else begin
               thr_ff <= pwdata[THR_W-1:0];
            end
         end

         // rearm: drop the sent values and force both axes next time
         if (req_fire && (req_data.req_type == REQ_REARM)) begin
            sent_x_ff <= '0;
            sent_y_ff <= '0;
            primed_ff <= 1'b0;
         end

         if (capture_live) live_ff <= live_c;

         // the sent value doubles as the beat payload during emit
         if (state_ff == ST_DECIDE) begin
            ev_x_ff   <= hit_x;
            ev_y_ff   <= hit_y;
            primed_ff <= 1'b1;
            if (hit_x) sent_x_ff <= shaped_x;
            if (hit_y) sent_y_ff <= shaped_y;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (ev_x_ff) begin
               ev_x_ff <= 1'b0;
            end else begin
               ev_y_ff <= 1'b0;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- payload regs
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff <= req_data.stick_x;
         y_ff <= req_data.stick_y;
      end
      if (out_load) begin
         if (ev_x_ff) begin
            rsp_data_ff.axis_id     <= AXIS_X;
            rsp_data_ff.axis_value  <= sent_x_ff;
            rsp_data_ff.last_of_run <= !ev_y_ff;
         end else begin
            rsp_data_ff.axis_id     <= AXIS_Y;
            rsp_data_ff.axis_value  <= sent_y_ff;
            rsp_data_ff.last_of_run <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- ports
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_THRESHOLD) ?
                      {{(DATA_W-THR_W){1'b0}}, thr_ff} :
                      {{(DATA_W-DZ_W){1'b0}}, dz_ff};

endmodule
